[rtl/ftwr_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, angle constants and arctangent table for the wheel rate pipeline.
// No dependencies.
package ftwr_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int MAX_ITER         = 30;

   localparam int XY_W    = 34;   // CORDIC x/y datapath
   localparam int ANGLE_W = 35;   // Q30 angle
   localparam int ERR_W   = 36;   // heading error before folding

   localparam int DIV_NB = 34;    // dividend / quotient bits
   localparam int DIV_DW = 16;    // divisor bits

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_HEADING_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_SCALE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_RADIUS = 2'd2;

   localparam logic [CSR_DATA_W-1:0] HEADING_GAIN_RST = 16'd4096;
   localparam logic [CSR_DATA_W-1:0] SPEED_SCALE_RST  = 16'd256;
   localparam logic [CSR_DATA_W-1:0] WHEEL_RADIUS_RST = 16'd256;

   localparam logic signed [ERR_W-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [ERR_W-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [ERR_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [XY_W-1:0]  INV_GAIN    = 34'sd652032874;

   localparam logic signed [14:0] HEADING_MAX = 15'sd12868;

   function automatic logic signed [ANGLE_W-1:0] atan_q30(input int i);
      logic signed [ANGLE_W-1:0] a;
      case (i)
         0:  a = 35'sh3243F6A8;
         1:  a = 35'sh1DAC6705;
         2:  a = 35'sh0FADBAFC;
         3:  a = 35'sh07F56EA6;
         4:  a = 35'sh03FEAB76;
         5:  a = 35'sh01FFD55B;
         6:  a = 35'sh00FFFAAA;
         7:  a = 35'sh007FFF55;
         8:  a = 35'sh003FFFEA;
         9:  a = 35'sh001FFFFD;
         10: a = 35'sh000FFFFF;
         11: a = 35'sh0007FFFF;
         12: a = 35'sh0003FFFF;
         13: a = 35'sh0001FFFF;
         14: a = 35'sh0000FFFF;
         15: a = 35'sh00007FFF;
         16: a = 35'sh00003FFF;
         17: a = 35'sh00001FFF;
         18: a = 35'sh00000FFF;
         19: a = 35'sh000007FF;
         20: a = 35'sh000003FF;
         21: a = 35'sh000001FF;
         22: a = 35'sh000000FF;
         23: a = 35'sh0000007F;
         24: a = 35'sh0000003F;
         25: a = 35'sh0000001F;
         26: a = 35'sh0000000F;
         27: a = 35'sh00000008;
         28: a = 35'sh00000004;
         29: a = 35'sh00000002;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

[rtl/ftwr_cordic.sv]
`timescale 1ns / 1ps
// Pipelined CORDIC, one micro-rotation per register stage, vectoring or rotation mode.
// Depends on ftwr_pkg (widths, arctangent table).
module ftwr_cordic #(
   parameter int STEPS  = ftwr_pkg::CORDIC_STEPS_DEF,
   parameter bit VECTOR = 1'b1,
   parameter int SIDE_W = 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [ftwr_pkg::XY_W-1:0]       in_x,
   input  logic signed [ftwr_pkg::XY_W-1:0]       in_y,
   input  logic signed [ftwr_pkg::ANGLE_W-1:0]    in_z,
   input  logic        [SIDE_W-1:0]               in_side,
   output logic                                   out_valid,
   output logic signed [ftwr_pkg::XY_W-1:0]       out_x,
   output logic signed [ftwr_pkg::XY_W-1:0]       out_y,
   output logic signed [ftwr_pkg::ANGLE_W-1:0]    out_z,
   output logic        [SIDE_W-1:0]               out_side
);

   localparam int ITERS = (STEPS > ftwr_pkg::MAX_ITER) ? ftwr_pkg::MAX_ITER : STEPS;
   localparam int XW = ftwr_pkg::XY_W;
   localparam int ZW = ftwr_pkg::ANGLE_W;

   logic                 valid_ff [1:ITERS];
   logic signed [XW-1:0] x_ff     [1:ITERS];
   logic signed [XW-1:0] y_ff     [1:ITERS];
   logic signed [ZW-1:0] z_ff     [1:ITERS];
   logic [SIDE_W-1:0]    side_ff  [1:ITERS];

   for (genvar i = 0; i < ITERS; i++) begin : g_step
      logic                 sv;
      logic signed [XW-1:0] sx, sy, xs, ys, x_in, y_in;
      logic signed [ZW-1:0] sz, z_in;
      logic [SIDE_W-1:0]    ss;
      logic                 up;

      if (i == 0) begin : g_first
         assign sv = in_valid;
         assign sx = in_x;
         assign sy = in_y;
         assign sz = in_z;
         assign ss = in_side;
      end else begin : g_next
         assign sv = valid_ff[i];
         assign sx = x_ff[i];
         assign sy = y_ff[i];
         assign sz = z_ff[i];
         assign ss = side_ff[i];
      end

      assign xs = sx >>> i;
      assign ys = sy >>> i;
      assign up = VECTOR ? sy[XW-1] : !sz[ZW-1];

      always_comb begin
         if (up) begin
            x_in = sx - ys;
            y_in = sy + xs;
            z_in = sz - ftwr_pkg::atan_q30(i);
         end else begin
            x_in = sx + ys;
            y_in = sy - xs;
            z_in = sz + ftwr_pkg::atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= sv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            side_ff[i+1] <= ss;
         end
      end
   end

   assign out_valid = valid_ff[ITERS];
   assign out_x     = x_ff[ITERS];
   assign out_y     = y_ff[ITERS];
   assign out_z     = z_ff[ITERS];
   assign out_side  = side_ff[ITERS];

endmodule

[rtl/ftwr_div.sv]
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider, one quotient bit per register stage.
// Depends on ftwr_pkg (dividend and divisor widths).
module ftwr_div #(
   parameter int SIDE_W = 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic [ftwr_pkg::DIV_DW-1:0]            divisor,
   input  logic                                   in_valid,
   input  logic [1:0][ftwr_pkg::DIV_NB-1:0]       in_dvd,
   input  logic [SIDE_W-1:0]                      in_side,
   output logic                                   out_valid,
   output logic [1:0][ftwr_pkg::DIV_NB-1:0]       out_quo,
   output logic [SIDE_W-1:0]                      out_side
);

   localparam int NB = ftwr_pkg::DIV_NB;
   localparam int DW = ftwr_pkg::DIV_DW;

   logic                    valid_ff [1:NB];
   logic [1:0][NB-1:0]      dvd_ff   [1:NB];
   logic [1:0][DW-1:0]      rem_ff   [1:NB];
   logic [SIDE_W-1:0]       side_ff  [1:NB];

   for (genvar i = 0; i < NB; i++) begin : g_step
      logic               sv;
      logic [1:0][NB-1:0] sdvd, dvd_in;
      logic [1:0][DW-1:0] srem, rem_in;
      logic [SIDE_W-1:0]  ss;

      if (i == 0) begin : g_first
         assign sv   = in_valid;
         assign sdvd = in_dvd;
         assign srem = '0;
         assign ss   = in_side;
      end else begin : g_next
         assign sv   = valid_ff[i];
         assign sdvd = dvd_ff[i];
         assign srem = rem_ff[i];
         assign ss   = side_ff[i];
      end

      always_comb begin
         logic [DW:0] trial;
         logic        ge;
         for (int l = 0; l < 2; l++) begin
            trial     = {srem[l], sdvd[l][NB-1]};
            ge        = (trial >= {1'b0, divisor});
            rem_in[l] = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
            dvd_in[l] = {sdvd[l][NB-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= sv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dvd_ff[i+1]  <= dvd_in;
            rem_ff[i+1]  <= rem_in;
            side_ff[i+1] <= ss;
         end
      end
   end

   assign out_valid = valid_ff[NB];
   assign out_quo   = dvd_ff[NB];
   assign out_side  = side_ff[NB];

endmodule

[rtl/force_to_wheel_rates.sv]
`timescale 1ns / 1ps
// Top level: force vector and heading in, differential wheel rates out.
// Depends on ftwr_pkg, ftwr_cordic, ftwr_div.
//
//   channel | dir | tdata fields (low bit up)                            | tuser
//   req     | in  | force_x[15:0] force_y[31:16] current_heading[46:32]  | -
//   rsp     | out | right[31:0] left[63:32] desired_heading[78:64]       | zero_force
//   csr     | in  | csr_we, csr_index, csr_wdata (16 bits)               | -
//
// One item per cycle sustained while results are accepted; the path runs through two CORDIC chains,
// 34 divider stages and six stages of setup, multiply, sum and output.
// Synchronous reset clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module force_to_wheel_rates #(
   parameter int CORDIC_STEPS = ftwr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [47:0]                         req_tdata,  // force_x, force_y, current_heading
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [79:0]                         rsp_tdata,  // right, left, desired_heading
   output logic [0:0]                          rsp_tuser,  // zero_force
   input  logic                                csr_we,
   input  logic [ftwr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ftwr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int XW = ftwr_pkg::XY_W;
   localparam int ZW = ftwr_pkg::ANGLE_W;
   localparam int EW = ftwr_pkg::ERR_W;
   localparam int NB = ftwr_pkg::DIV_NB;
   localparam int RS = 33;   // rotation sideband: neg, zero, d12, herr
   localparam int DS = 20;   // divider sideband: zero, d12, sign/nz per lane

   localparam logic signed [ZW-1:0] RND18   = 35'sd131072;
   localparam logic signed [50:0]   RND22   = 51'sd2097152;
   localparam logic signed [32:0]   RND8    = 33'sd128;

   function automatic logic [31:0] wheel_rate(input logic [NB-1:0] q, input logic s,
                                              input logic nz, input logic rz);
      logic [31:0] r;
      if (rz) begin
         r = nz ? (s ? 32'h8000_0000 : 32'h7FFF_FFFF) : 32'h0;
      end else if (!s) begin
         r = (q > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end else begin
         r = (q > 34'h0_8000_0000) ? 32'h8000_0000 : (32'h0 - q[31:0]);
      end
      return r;
   endfunction

   // configuration
   logic [15:0] gain_ff, speed_ff, radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= ftwr_pkg::HEADING_GAIN_RST;
         speed_ff  <= ftwr_pkg::SPEED_SCALE_RST;
         radius_ff <= ftwr_pkg::WHEEL_RADIUS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ftwr_pkg::REG_HEADING_GAIN: gain_ff   <= csr_wdata;
            ftwr_pkg::REG_SPEED_SCALE:  speed_ff  <= csr_wdata;
            ftwr_pkg::REG_WHEEL_RADIUS: radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic advance;
   logic rsp_valid_ff;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // stage A: quadrant pre-rotation
   logic signed [15:0] fx, fy;
   logic signed [14:0] hd;
   logic signed [16:0] px, py;
   logic signed [XW-1:0] a_x_in;
   logic signed [XW-1:0] a_y_in;
   logic signed [ZW-1:0] a_z_in;
   logic a_valid_ff, a_zero_ff;
   logic signed [XW-1:0] a_x_ff, a_y_ff;
   logic signed [ZW-1:0] a_z_ff;
   logic signed [14:0]   a_h_ff;

   assign fx = req_tdata[15:0];
   assign fy = req_tdata[31:16];
   assign hd = req_tdata[46:32];

   always_comb begin
      if (fx[15] && !fy[15]) begin
         px     = 17'(fy);
         py     = -17'(fx);
         a_z_in = ZW'(ftwr_pkg::Q30_HALF_PI);
      end else if (fx[15]) begin
         px     = -17'(fy);
         py     = 17'(fx);
         a_z_in = -ZW'(ftwr_pkg::Q30_HALF_PI);
      end else begin
         px     = 17'(fx);
         py     = 17'(fy);
         a_z_in = '0;
      end
      a_x_in = XW'(px) <<< 14;
      a_y_in = XW'(py) <<< 14;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_x_ff    <= a_x_in;
         a_y_ff    <= a_y_in;
         a_z_ff    <= a_z_in;
         a_h_ff    <= hd;
         a_zero_ff <= (fx == 16'sd0) && (fy == 16'sd0);
      end
   end

   // vectoring: desired heading
   logic                 v_valid;
   logic signed [ZW-1:0] v_z;
   logic [15:0]          v_side;

   ftwr_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1), .SIDE_W(16)) u_vec (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .in_valid (a_valid_ff),
      .in_x     (a_x_ff),
      .in_y     (a_y_ff),
      .in_z     (a_z_ff),
      .in_side  ({a_zero_ff, a_h_ff}),
      .out_valid(v_valid),
      .out_x    (),
      .out_y    (),
      .out_z    (v_z),
      .out_side (v_side)
   );

   // stage B: round heading, heading error, fold cosine argument
   logic signed [14:0]   v_h;
   logic signed [ZW-1:0] d12w, rcorr;
   logic signed [14:0]   b_d12_in;
   logic signed [EW-1:0] e0, e1, e2, e3;
   logic                 b_neg_in;
   logic b_valid_ff, b_zero_ff, b_neg_ff;
   logic signed [ZW-1:0] b_e_ff;
   logic signed [15:0]   b_herr_ff;
   logic signed [14:0]   b_d12_ff;

   assign v_h = v_side[14:0];

   always_comb begin
      rcorr = v_z[ZW-1] ? (RND18 - ZW'(1)) : RND18;
      d12w  = (v_z + rcorr) >>> 18;
      if (d12w > ZW'(ftwr_pkg::HEADING_MAX)) begin
         b_d12_in = ftwr_pkg::HEADING_MAX;
      end else if (d12w < -ZW'(ftwr_pkg::HEADING_MAX)) begin
         b_d12_in = -ftwr_pkg::HEADING_MAX;
      end else begin
         b_d12_in = 15'(d12w);
      end
      e0 = EW'(v_z) - (EW'(v_h) <<< 18);
      e1 = (e0 > ftwr_pkg::Q30_PI) ? (e0 - ftwr_pkg::Q30_TWO_PI) : e0;
      e2 = (e1 < -ftwr_pkg::Q30_PI) ? (e1 + ftwr_pkg::Q30_TWO_PI) : e1;
      b_neg_in = 1'b1;
      if (e2 > ftwr_pkg::Q30_HALF_PI) begin
         e3 = ftwr_pkg::Q30_PI - e2;
      end else if (e2 < -ftwr_pkg::Q30_HALF_PI) begin
         e3 = -ftwr_pkg::Q30_PI - e2;
      end else begin
         e3       = e2;
         b_neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= v_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_e_ff    <= ZW'(e3);
         b_neg_ff  <= b_neg_in;
         b_zero_ff <= v_side[15];
         b_d12_ff  <= b_d12_in;
         b_herr_ff <= 16'(b_d12_in) - 16'(v_h);
      end
   end

   // rotation: cosine of heading error
   logic                 r_valid;
   logic signed [XW-1:0] r_x;
   logic [RS-1:0]        r_side;

   ftwr_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .SIDE_W(RS)) u_rot (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .in_valid (b_valid_ff),
      .in_x     (ftwr_pkg::INV_GAIN),
      .in_y     ('0),
      .in_z     (b_e_ff),
      .in_side  ({b_neg_ff, b_zero_ff, b_d12_ff, b_herr_ff}),
      .out_valid(r_valid),
      .out_x    (r_x),
      .out_y    (),
      .out_z    (),
      .out_side (r_side)
   );

   // stage C: products
   logic signed [XW-1:0] cosv;
   logic c_valid_ff, c_zero_ff;
   logic signed [50:0] c_pv_ff;
   logic signed [32:0] c_pw_ff;
   logic signed [14:0] c_d12_ff;

   assign cosv = r_side[32] ? -r_x : r_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_pv_ff   <= $signed({1'b0, speed_ff}) * cosv;
         c_pw_ff   <= $signed({1'b0, gain_ff}) * $signed(r_side[15:0]);
         c_zero_ff <= r_side[31];
         c_d12_ff  <= r_side[30:16];
      end
   end

   // stage D: rounding to Q16.16
   logic signed [50:0] vcorr;
   logic signed [32:0] wcorr;
   logic signed [50:0] v_rnd;
   logic signed [32:0] w_rnd;
   logic d_valid_ff, d_zero_ff;
   logic signed [29:0] d_v_ff;
   logic signed [25:0] d_w_ff;
   logic signed [14:0] d_d12_ff;

   assign vcorr = c_pv_ff[50] ? (RND22 - 51'sd1) : RND22;
   assign wcorr = c_pw_ff[32] ? (RND8 - 33'sd1) : RND8;
   assign v_rnd = (c_pv_ff + vcorr) >>> 22;
   assign w_rnd = (c_pw_ff + wcorr) >>> 8;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_v_ff    <= 30'(v_rnd);
         d_w_ff    <= 26'(w_rnd);
         d_zero_ff <= c_zero_ff;
         d_d12_ff  <= c_d12_ff;
      end
   end

   // stage E: wheel numerators, sign and magnitude
   logic signed [26:0] nr, nl, mr, ml;
   logic e_valid_ff;
   logic [1:0][NB-1:0] e_dvd_ff;
   logic [DS-1:0]      e_side_ff;

   assign nr = 27'(d_v_ff) + 27'(d_w_ff);
   assign nl = 27'(d_v_ff) - 27'(d_w_ff);
   assign mr = nr[26] ? -nr : nr;
   assign ml = nl[26] ? -nl : nl;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_dvd_ff[0] <= {mr[25:0], 8'h00};
         e_dvd_ff[1] <= {ml[25:0], 8'h00};
         e_side_ff   <= {d_zero_ff, d_d12_ff, nr[26], (nr != 27'sd0), nl[26], (nl != 27'sd0)};
      end
   end

   // division by wheel radius
   logic               q_valid;
   logic [1:0][NB-1:0] q_quo;
   logic [DS-1:0]      q_side;

   ftwr_div #(.SIDE_W(DS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .divisor  (radius_ff),
      .in_valid (e_valid_ff),
      .in_dvd   (e_dvd_ff),
      .in_side  (e_side_ff),
      .out_valid(q_valid),
      .out_quo  (q_quo),
      .out_side (q_side)
   );

   // output register: saturation, zero force override
   logic        rz, q_zero;
   logic [31:0] rsp_right_ff, rsp_left_ff;
   logic [14:0] rsp_dh_ff;
   logic        rsp_zero_ff;

   assign rz     = (radius_ff == 16'd0);
   assign q_zero = q_side[19];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_right_ff <= q_zero ? 32'h0 : wheel_rate(q_quo[0], q_side[3], q_side[2], rz);
         rsp_left_ff  <= q_zero ? 32'h0 : wheel_rate(q_quo[1], q_side[1], q_side[0], rz);
         rsp_dh_ff    <= q_zero ? 15'h0 : q_side[18:4];
         rsp_zero_ff  <= q_zero;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_dh_ff, rsp_left_ff, rsp_right_ff};
   assign rsp_tuser  = rsp_zero_ff;

`ifndef SYNTH
   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[78:0] == 79'h0)
      else $error("zero force result carries nonzero fields");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[78:64]) <= ftwr_pkg::HEADING_MAX) &&
                     ($signed(rsp_tdata[78:64]) >= -ftwr_pkg::HEADING_MAX))
      else $error("desired heading outside clamp range");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule
